// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MMBD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define MMBD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `MMBD_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

// ----- rtl/core/mmbd_pkg.sv -----
// Shared constants, types and codes of the mirrored memory bus decoder.
package mmbd_pkg;

  localparam int unsigned RAM_BYTES  = 2097152;
  localparam int unsigned BIOS_BYTES = 524288;
  localparam int unsigned IO_BYTES   = 4096;
  localparam int unsigned PAGE_SHIFT = 16;
  localparam int unsigned PAGE_W     = 32 - PAGE_SHIFT;
  localparam int unsigned PAGE_BYTES = 1 << PAGE_SHIFT;

  localparam int unsigned RAM_PAGES  = (RAM_BYTES + PAGE_BYTES - 1) >> PAGE_SHIFT;
  localparam int unsigned BIOS_PAGES = (BIOS_BYTES + PAGE_BYTES - 1) >> PAGE_SHIFT;

  localparam int unsigned RAM_AW  = $clog2(RAM_BYTES);
  localparam int unsigned BIOS_AW = $clog2(BIOS_BYTES);
  localparam int unsigned IO_AW   = $clog2(IO_BYTES);
  localparam int unsigned OFF_W   = (RAM_AW > BIOS_AW) ? RAM_AW : BIOS_AW;

  localparam int unsigned LANES          = 4;
  localparam int unsigned RAM_BANK_DEPTH  = (RAM_BYTES + LANES - 1) / LANES;
  localparam int unsigned BIOS_BANK_DEPTH = (BIOS_BYTES + LANES - 1) / LANES;
  localparam int unsigned IO_BANK_DEPTH   = (IO_BYTES + LANES - 1) / LANES;

  localparam logic [31:0] RAM_BASES  [3] = '{32'h0000_0000, 32'h8000_0000, 32'hA000_0000};
  localparam logic [31:0] BIOS_BASES [3] = '{32'h1FC0_0000, 32'h9FC0_0000, 32'hBFC0_0000};
  localparam logic [31:0] IO_FIRST = 32'h1F80_1000;
  localparam logic [31:0] IO_END   = 32'h1F80_2000;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_READ_BYTE  = 2'd0,
    ACT_READ_WORD  = 2'd1,
    ACT_WRITE_BYTE = 2'd2,
    ACT_WRITE_WORD = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_RAM  = 2'd1,
    TGT_BIOS = 2'd2,
    TGT_IO   = 2'd3
  } target_e;

  typedef struct packed {
    target_e          tgt;
    logic [OFF_W-1:0] off;
    logic [7:0]       data;
  } lane_t;

  typedef struct packed {
    logic              wr;
    lane_t [LANES-1:0] lane;
  } cmd_t;

endpackage

// ----- rtl/core/mmbd_if.sv -----
// Request and response channel interfaces of the mirrored memory bus decoder.
interface mmbd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] address;
  logic [31:0] write_data;

  modport source (output valid, output action, output address, output write_data,
                  input ready);
  modport sink (input valid, input action, input address, input write_data,
                output ready);
endinterface

interface mmbd_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

// ----- rtl/core/mmbd_front.sv -----
// Front end: splits each access into byte lanes and decodes each lane to a store.
module mmbd_front (
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [1:0]       action_i,
  input  logic [31:0]      address_i,
  input  logic [31:0]      write_data_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output mmbd_pkg::cmd_t   push_cmd_o
);

  function automatic mmbd_pkg::lane_t decode_byte(input logic [31:0] addr,
                                                  input logic [7:0] data);
    mmbd_pkg::lane_t              l;
    logic [mmbd_pkg::PAGE_W-1:0]  page;
    logic [mmbd_pkg::PAGE_W-1:0]  rel;
    logic [31:0]                  off;
    logic                         hit;
    l.tgt = mmbd_pkg::TGT_NONE;
    l.off = '0;
    l.data = data;
    hit = 1'b0;
    page = addr[31:mmbd_pkg::PAGE_SHIFT];
    for (int i = 0; i < 3; i++) begin
      rel = page - mmbd_pkg::RAM_BASES[i][31:mmbd_pkg::PAGE_SHIFT];
      if (!hit && ({16'd0, rel} < mmbd_pkg::RAM_PAGES)) begin
        hit = 1'b1;
        off = {rel, addr[mmbd_pkg::PAGE_SHIFT-1:0]};
        if (off < mmbd_pkg::RAM_BYTES) begin
          l.tgt = mmbd_pkg::TGT_RAM;
          l.off = off[mmbd_pkg::OFF_W-1:0];
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      rel = page - mmbd_pkg::BIOS_BASES[i][31:mmbd_pkg::PAGE_SHIFT];
      if (!hit && ({16'd0, rel} < mmbd_pkg::BIOS_PAGES)) begin
        hit = 1'b1;
        off = {rel, addr[mmbd_pkg::PAGE_SHIFT-1:0]};
        if (off < mmbd_pkg::BIOS_BYTES) begin
          l.tgt = mmbd_pkg::TGT_BIOS;
          l.off = off[mmbd_pkg::OFF_W-1:0];
        end
      end
    end
    if (!hit && (addr >= mmbd_pkg::IO_FIRST) && (addr < mmbd_pkg::IO_END)) begin
      l.tgt = mmbd_pkg::TGT_IO;
      l.off = mmbd_pkg::OFF_W'(addr[mmbd_pkg::IO_AW-1:0]);
    end
    return l;
  endfunction

  mmbd_pkg::action_e act;
  logic              is_word;

  assign act = mmbd_pkg::action_e'(action_i);
  assign is_word = (act == mmbd_pkg::ACT_READ_WORD) || (act == mmbd_pkg::ACT_WRITE_WORD);

  always_comb begin
    push_cmd_o.wr = (act == mmbd_pkg::ACT_WRITE_BYTE) || (act == mmbd_pkg::ACT_WRITE_WORD);
    for (int k = 0; k < mmbd_pkg::LANES; k++) begin
      push_cmd_o.lane[k] = decode_byte(address_i + 32'(k), write_data_i[8*k +: 8]);
      if (!is_word && (k != 0)) begin
        push_cmd_o.lane[k].tgt = mmbd_pkg::TGT_NONE;
      end
    end
  end

  assign push_valid_o = valid_i;
  assign ready_o = push_ready_i;

endmodule

// ----- rtl/core/mmbd_queue.sv -----
// Short command queue between the decoding front end and the memory back end.
module mmbd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  mmbd_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output mmbd_pkg::cmd_t pop_cmd_o
);

  mmbd_pkg::cmd_t                entry_q [mmbd_pkg::QUEUE_DEPTH];
  logic [mmbd_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [mmbd_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [mmbd_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                          push;
  logic                          pop;

  assign push_ready_o = (count_q != mmbd_pkg::QCNT_W'(mmbd_pkg::QUEUE_DEPTH));
  assign pop_valid_o = (count_q != '0);
  assign pop_cmd_o = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- rtl/core/mmbd_bank_ram.sv -----
// Single-port byte-wide RAM bank with registered read data.
module mmbd_bank_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mmbd_back.sv -----
// Back end: drives the byte-lane banks of each store and assembles read beats.
module mmbd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  mmbd_pkg::cmd_t cmd_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output logic [31:0]    rsp_data_o
);

  localparam int unsigned L = mmbd_pkg::LANES;

  logic [L-1:0]               ram_en, bios_en, io_en;
  logic [mmbd_pkg::OFF_W-1:0] ram_addr [L];
  logic [mmbd_pkg::OFF_W-1:0] bios_addr [L];
  logic [mmbd_pkg::OFF_W-1:0] io_addr [L];
  logic [7:0]                 ram_wd [L];
  logic [7:0]                 bios_wd [L];
  logic [7:0]                 io_wd [L];
  logic [7:0]                 ram_rd [L];
  logic [7:0]                 bios_rd [L];
  logic [7:0]                 io_rd [L];

  logic                       pop;
  logic                       r_move;
  logic                       r_valid_q, r_valid_d;
  mmbd_pkg::target_e          r_tgt_q [L];
  logic [1:0]                 r_bank_q [L];
  logic                       out_valid_q, out_valid_d;
  logic [31:0]                out_data_q;
  logic [31:0]                assembled;

  assign r_move = r_valid_q && (!out_valid_q || rsp_ready_i);
  assign cmd_ready_o = cmd_i.wr || !r_valid_q || r_move;
  assign pop = cmd_valid_i && cmd_ready_o;

  always_comb begin
    for (int b = 0; b < L; b++) begin
      ram_en[b] = 1'b0;
      bios_en[b] = 1'b0;
      io_en[b] = 1'b0;
      ram_addr[b] = '0;
      bios_addr[b] = '0;
      io_addr[b] = '0;
      ram_wd[b] = '0;
      bios_wd[b] = '0;
      io_wd[b] = '0;
      for (int k = 0; k < L; k++) begin
        if (cmd_i.lane[k].off[1:0] == 2'(b)) begin
          case (cmd_i.lane[k].tgt)
            mmbd_pkg::TGT_RAM: begin
              ram_en[b] = pop;
              ram_addr[b] = cmd_i.lane[k].off;
              ram_wd[b] = cmd_i.lane[k].data;
            end
            mmbd_pkg::TGT_BIOS: begin
              bios_en[b] = pop;
              bios_addr[b] = cmd_i.lane[k].off;
              bios_wd[b] = cmd_i.lane[k].data;
            end
            mmbd_pkg::TGT_IO: begin
              io_en[b] = pop;
              io_addr[b] = cmd_i.lane[k].off;
              io_wd[b] = cmd_i.lane[k].data;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  for (genvar b = 0; b < L; b++) begin : g_bank
    mmbd_bank_ram #(
      .Depth(mmbd_pkg::RAM_BANK_DEPTH),
      .AddrW(mmbd_pkg::RAM_AW - 2)
    ) u_ram (
      .clk_i  (clk_i),
      .en_i   (ram_en[b]),
      .we_i   (cmd_i.wr),
      .addr_i (ram_addr[b][mmbd_pkg::RAM_AW-1:2]),
      .wdata_i(ram_wd[b]),
      .rdata_o(ram_rd[b])
    );

    mmbd_bank_ram #(
      .Depth(mmbd_pkg::BIOS_BANK_DEPTH),
      .AddrW(mmbd_pkg::BIOS_AW - 2)
    ) u_bios (
      .clk_i  (clk_i),
      .en_i   (bios_en[b]),
      .we_i   (cmd_i.wr),
      .addr_i (bios_addr[b][mmbd_pkg::BIOS_AW-1:2]),
      .wdata_i(bios_wd[b]),
      .rdata_o(bios_rd[b])
    );

    mmbd_bank_ram #(
      .Depth(mmbd_pkg::IO_BANK_DEPTH),
      .AddrW(mmbd_pkg::IO_AW - 2)
    ) u_io (
      .clk_i  (clk_i),
      .en_i   (io_en[b]),
      .we_i   (cmd_i.wr),
      .addr_i (io_addr[b][mmbd_pkg::IO_AW-1:2]),
      .wdata_i(io_wd[b]),
      .rdata_o(io_rd[b])
    );
  end

  always_comb begin
    for (int k = 0; k < L; k++) begin
      case (r_tgt_q[k])
        mmbd_pkg::TGT_RAM:  assembled[8*k +: 8] = ram_rd[r_bank_q[k]];
        mmbd_pkg::TGT_BIOS: assembled[8*k +: 8] = bios_rd[r_bank_q[k]];
        mmbd_pkg::TGT_IO:   assembled[8*k +: 8] = io_rd[r_bank_q[k]];
        default:            assembled[8*k +: 8] = 8'h00;
      endcase
    end
  end

  always_comb begin
    r_valid_d = r_valid_q;
    if (pop && !cmd_i.wr) begin
      r_valid_d = 1'b1;
    end else if (r_move) begin
      r_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (r_move) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      r_valid_q <= r_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !cmd_i.wr) begin
      for (int k = 0; k < L; k++) begin
        r_tgt_q[k] <= cmd_i.lane[k].tgt;
        r_bank_q[k] <= cmd_i.lane[k].off[1:0];
      end
    end
    if (r_move) begin
      out_data_q <= assembled;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_data_o = out_data_q;

endmodule

// ----- rtl/core/mirrored_memory_bus_decoder_core.sv -----
// Top level of the mirrored memory bus decoder: front end, command queue and back end.
//
//   Channel   Dir   Beat contents
//   req_i     in    action, address, write_data
//   rsp_o     out   read_data (one beat per read, none per write)
//
// One access is accepted per cycle while the command queue has room; the rate is set by the
// single-port byte-lane banks, which serve each of the four bytes of a word in one access.
// A read beat passes through the command queue, a bank read register and the output register.
// Reset clears only control state; store contents are undefined until written.
// The two-entry command queue lets the request side keep going while a read beat waits.
module mirrored_memory_bus_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmbd_req_if.sink   req_i,
  mmbd_rsp_if.source rsp_o
);

  logic           push_valid;
  logic           push_ready;
  mmbd_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  mmbd_pkg::cmd_t pop_cmd;

  mmbd_front u_front (
    .valid_i     (req_i.valid),
    .ready_o     (req_i.ready),
    .action_i    (req_i.action),
    .address_i   (req_i.address),
    .write_data_i(req_i.write_data),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  mmbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  mmbd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(pop_valid),
    .cmd_ready_o(pop_ready),
    .cmd_i      (pop_cmd),
    .rsp_valid_o(rsp_o.valid),
    .rsp_ready_i(rsp_o.ready),
    .rsp_data_o (rsp_o.read_data)
  );

endmodule

// ----- rtl/core/mmbd_checker.sv -----
// Port-level checker of the mirrored memory bus decoder and its bind statement.
`include "assert_macros.svh"

module mmbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic [1:0]  req_action_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_read_data_i
);

  logic       req_acc;
  logic       rsp_acc;
  logic       is_read;
  logic [2:0] outstanding_q, outstanding_d;

  assign req_acc = req_valid_i && req_ready_i;
  assign rsp_acc = rsp_valid_i && rsp_ready_i;
  assign is_read = (req_action_i == mmbd_pkg::ACT_READ_BYTE) ||
                   (req_action_i == mmbd_pkg::ACT_READ_WORD);

  always_comb begin
    outstanding_d = outstanding_q;
    if (req_acc && is_read && !rsp_acc) begin
      outstanding_d = outstanding_q + 3'd1;
    end else if (rsp_acc && !(req_acc && is_read)) begin
      outstanding_d = outstanding_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_d;
    end
  end

  `MMBD_ASSERT(a_rsp_hold, clk_i, rst_ni,
               rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_read_data_i),
               "Read beat dropped or changed while stalled.")
  `MMBD_ASSERT(a_rsp_after_read, clk_i, rst_ni,
               rsp_valid_i |-> outstanding_q != 3'd0,
               "Read beat without an accepted read.")
  `MMBD_ASSERT_NEVER(a_depth_bound, clk_i, rst_ni,
                     outstanding_q > 3'd4,
                     "More reads in flight than the core can hold.")
  `MMBD_ASSERT(a_write_silent, clk_i, rst_ni,
               req_acc && !is_read && outstanding_q == 3'd0 |=> !rsp_valid_i,
               "Write produced a read beat.")

endmodule

bind mirrored_memory_bus_decoder_core mmbd_checker u_mmbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_action_i   (req_i.action),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_read_data_i(rsp_o.read_data)
);

// ----- dv/mirrored_memory_bus_decoder_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the mirrored memory bus decoder core with a byte-level shadow store.
module mirrored_memory_bus_decoder_core_tb;

  localparam int unsigned ROWS            = 24;
  localparam int unsigned RANDOM_ACCESSES = 1925;
  localparam int unsigned CALM_TAIL       = 250;
  localparam int unsigned HOLD_AFTER      = 400;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned POOL_MAX        = 512;

  typedef struct packed {
    mmbd_pkg::action_e act;
    logic [31:0]       addr;
    logic [31:0]       data;
    logic              typed;
    logic [31:0]       want;
  } vector_t;

  localparam vector_t DIRECTED [ROWS] = '{
    '{mmbd_pkg::ACT_READ_BYTE,  32'h1F80_0FFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_WORD,  32'h1F80_2000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{mmbd_pkg::ACT_WRITE_WORD, 32'h0000_0000, 32'hA1B2_C3D4, 1'b0, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_WORD,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hB2C3_D400},
    '{mmbd_pkg::ACT_READ_WORD,  32'h8000_0000, 32'h0000_0000, 1'b1, 32'hA1B2_C3D4},
    '{mmbd_pkg::ACT_READ_BYTE,  32'hA000_0003, 32'h0000_0000, 1'b1, 32'h0000_00A1},
    '{mmbd_pkg::ACT_WRITE_BYTE, 32'h001F_FFFF, 32'hFFFF_FF5A, 1'b0, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_WORD,  32'h801F_FFFF, 32'h0000_0000, 1'b1, 32'h0000_005A},
    '{mmbd_pkg::ACT_WRITE_WORD, 32'h1FC7_FFFE, 32'h1122_3344, 1'b0, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_WORD,  32'hBFC7_FFFE, 32'h0000_0000, 1'b1, 32'h0000_3344},
    '{mmbd_pkg::ACT_WRITE_WORD, 32'h1F80_1FFE, 32'hCAFE_BABE, 1'b0, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_WORD,  32'h1F80_1FFE, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{mmbd_pkg::ACT_WRITE_BYTE, 32'h1F80_1000, 32'hFFFF_FF00, 1'b0, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_BYTE,  32'h1F80_1000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{mmbd_pkg::ACT_WRITE_WORD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_WORD,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'hA1B2_FFFF},
    '{mmbd_pkg::ACT_WRITE_BYTE, 32'h9FC0_0000, 32'h0000_0077, 1'b0, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_BYTE,  32'h1FC0_0000, 32'h0000_0000, 1'b1, 32'h0000_0077},
    '{mmbd_pkg::ACT_WRITE_WORD, 32'h7FFF_FFFF, 32'h0102_0304, 1'b0, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_WORD,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'hA101_0203},
    '{mmbd_pkg::ACT_READ_WORD,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h0102_0300},
    '{mmbd_pkg::ACT_WRITE_BYTE, 32'hFFFF_FFFF, 32'h0000_00AB, 1'b0, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_BYTE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{mmbd_pkg::ACT_READ_BYTE,  32'hA01F_FFFF, 32'h0000_0000, 1'b1, 32'h0000_005A}
  };

  logic clk;
  logic rst_n;

  mmbd_req_if req_bus ();
  mmbd_rsp_if rsp_bus ();

  mirrored_memory_bus_decoder_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  logic [7:0]  shadow_bytes [int unsigned];
  logic [31:0] read_expectations [$];
  logic [31:0] written_addrs [$];
  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  function automatic bit find_cell(input logic [31:0] a, output int unsigned key);
    logic [31:0] rel;
    logic [31:0] off;
    key = 0;
    for (int i = 0; i < 3; i++) begin
      rel = (a >> mmbd_pkg::PAGE_SHIFT) - (mmbd_pkg::RAM_BASES[i] >> mmbd_pkg::PAGE_SHIFT);
      if (rel < mmbd_pkg::RAM_PAGES) begin
        off = (rel << mmbd_pkg::PAGE_SHIFT) | (a & (mmbd_pkg::PAGE_BYTES - 1));
        key = {6'd0, mmbd_pkg::TGT_RAM, off[23:0]};
        return off < mmbd_pkg::RAM_BYTES;
      end
    end
    for (int i = 0; i < 3; i++) begin
      rel = (a >> mmbd_pkg::PAGE_SHIFT) - (mmbd_pkg::BIOS_BASES[i] >> mmbd_pkg::PAGE_SHIFT);
      if (rel < mmbd_pkg::BIOS_PAGES) begin
        off = (rel << mmbd_pkg::PAGE_SHIFT) | (a & (mmbd_pkg::PAGE_BYTES - 1));
        key = {6'd0, mmbd_pkg::TGT_BIOS, off[23:0]};
        return off < mmbd_pkg::BIOS_BYTES;
      end
    end
    if (a >= mmbd_pkg::IO_FIRST && a < mmbd_pkg::IO_END) begin
      off = a & (mmbd_pkg::IO_BYTES - 1);
      key = {6'd0, mmbd_pkg::TGT_IO, off[23:0]};
      return off < mmbd_pkg::IO_BYTES;
    end
    return 1'b0;
  endfunction

  function automatic bit read_defined(input mmbd_pkg::action_e act, input logic [31:0] a);
    int unsigned k;
    int          lanes;
    lanes = (act == mmbd_pkg::ACT_READ_WORD) ? 4 : 1;
    for (int b = 0; b < lanes; b++) begin
      if (find_cell(a + 32'(b), k) && !shadow_bytes.exists(k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void bus_access(input mmbd_pkg::action_e act, input logic [31:0] a,
                                     input logic [31:0] d, output bit answers,
                                     output logic [31:0] word);
    int unsigned k;
    word = '0;
    answers = (act == mmbd_pkg::ACT_READ_BYTE || act == mmbd_pkg::ACT_READ_WORD);
    for (int b = 0; b < 4; b++) begin
      if (b == 0 || act == mmbd_pkg::ACT_READ_WORD || act == mmbd_pkg::ACT_WRITE_WORD) begin
        if (find_cell(a + 32'(b), k)) begin
          if (answers) word[8*b +: 8] = shadow_bytes.exists(k) ? shadow_bytes[k] : 8'h00;
          else shadow_bytes[k] = d[8*b +: 8];
        end
      end
    end
  endfunction

  function automatic logic [31:0] any_address();
    logic [31:0] brink;
    case ($urandom_range(0, 9))
      0, 1, 2: return mmbd_pkg::RAM_BASES[$urandom_range(0, 2)] +
                      $urandom_range(0, mmbd_pkg::RAM_BYTES - 1);
      3, 4:    return mmbd_pkg::BIOS_BASES[$urandom_range(0, 2)] +
                      $urandom_range(0, mmbd_pkg::BIOS_BYTES - 1);
      5:       return mmbd_pkg::IO_FIRST + $urandom_range(0, mmbd_pkg::IO_BYTES - 1);
      6, 7: begin
        case ($urandom_range(0, 4))
          0:       brink = mmbd_pkg::RAM_BASES[$urandom_range(0, 2)] + mmbd_pkg::RAM_BYTES;
          1:       brink = mmbd_pkg::BIOS_BASES[$urandom_range(0, 2)] + mmbd_pkg::BIOS_BYTES;
          2:       brink = mmbd_pkg::IO_FIRST;
          3:       brink = mmbd_pkg::IO_END;
          default: brink = 32'h0000_0000;
        endcase
        return brink + $urandom_range(0, 6) - 3;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] swap_mirror(input logic [31:0] a);
    int unsigned k;
    k = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      if (a - mmbd_pkg::RAM_BASES[i] < mmbd_pkg::RAM_BYTES)
        return mmbd_pkg::RAM_BASES[k] + (a - mmbd_pkg::RAM_BASES[i]);
    end
    for (int i = 0; i < 3; i++) begin
      if (a - mmbd_pkg::BIOS_BASES[i] < mmbd_pkg::BIOS_BYTES)
        return mmbd_pkg::BIOS_BASES[k] + (a - mmbd_pkg::BIOS_BASES[i]);
    end
    return a;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d: %s expected %08h actual %08h", mismatch_count, what, want, got);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic issue(input mmbd_pkg::action_e act, input logic [31:0] a,
                       input logic [31:0] d, input bit typed, input logic [31:0] want);
    bit          answers;
    logic [31:0] word;
    req_bus.valid      <= 1'b1;
    req_bus.action     <= act;
    req_bus.address    <= a;
    req_bus.write_data <= d;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    bus_access(act, a, d, answers, word);
    if (answers) begin
      read_expectations.push_back(typed ? want : word);
    end else begin
      written_addrs.push_back(a);
      if (written_addrs.size() > POOL_MAX) void'(written_addrs.pop_front());
    end
    beats_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    do begin
      @(posedge clk);
      cycle_count++;
    end while (cycle_count < CYCLE_LIMIT);
    $display("mirrored_memory_bus_decoder_core regression: fail");
    $finish;
  end

  initial begin : receiver
    bit          level;
    bit          held;
    int unsigned span;
    held = 1'b0;
    rsp_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (calm) begin
        level = 1'b1;
        span = 1;
      end else if (!held && beats_sent >= HOLD_AFTER) begin
        level = 1'b0;
        span = HOLD_CYCLES;
        held = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        level = 1'b0;
        span = $urandom_range(1, 17);
      end else begin
        level = 1'b1;
        span = $urandom_range(1, 40);
      end
      rsp_bus.ready <= level;
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (read_expectations.size() == 0) begin
        note_mismatch("read beat with none pending", 'x, rsp_bus.read_data);
      end else begin
        if (rsp_bus.read_data !== read_expectations[0])
          note_mismatch("read_data", read_expectations[0], rsp_bus.read_data);
        void'(read_expectations.pop_front());
      end
    end
  end

  initial begin : stimulus
    mmbd_pkg::action_e act;
    logic [31:0]       addr;
    int unsigned       roll;
    rst_n              <= 1'b0;
    req_bus.valid      <= 1'b0;
    req_bus.action     <= mmbd_pkg::ACT_READ_BYTE;
    req_bus.address    <= '0;
    req_bus.write_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      maybe_pause();
      issue(DIRECTED[r].act, DIRECTED[r].addr, DIRECTED[r].data, DIRECTED[r].typed,
            DIRECTED[r].want);
    end

    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      calm = (n >= RANDOM_ACCESSES - CALM_TAIL);
      maybe_pause();
      roll = $urandom_range(0, 99);
      act = (roll < 28) ? mmbd_pkg::ACT_READ_BYTE : (roll < 56) ? mmbd_pkg::ACT_READ_WORD :
            (roll < 76) ? mmbd_pkg::ACT_WRITE_BYTE : mmbd_pkg::ACT_WRITE_WORD;
      if ((act == mmbd_pkg::ACT_READ_BYTE || act == mmbd_pkg::ACT_READ_WORD) &&
          written_addrs.size() != 0 && $urandom_range(0, 4) != 0)
        addr = swap_mirror(written_addrs[$urandom_range(0, written_addrs.size() - 1)] +
                           $urandom_range(0, 4) - 2);
      else
        addr = any_address();
      // A read that would touch a byte never stored becomes a word write to the same place.
      if ((act == mmbd_pkg::ACT_READ_BYTE || act == mmbd_pkg::ACT_READ_WORD) &&
          !read_defined(act, addr))
        act = mmbd_pkg::ACT_WRITE_WORD;
      issue(act, addr, $urandom, 1'b0, '0);
    end
    req_bus.valid <= 1'b0;

    while (read_expectations.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && read_expectations.size() == 0)
      $display("mirrored_memory_bus_decoder_core regression: pass");
    else
      $display("mirrored_memory_bus_decoder_core regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mmbd_pkg.sv
rtl/core/mmbd_if.sv
rtl/core/mmbd_front.sv
rtl/core/mmbd_queue.sv
rtl/core/mmbd_bank_ram.sv
rtl/core/mmbd_back.sv
rtl/core/mirrored_memory_bus_decoder_core.sv
rtl/core/mmbd_checker.sv
dv/mirrored_memory_bus_decoder_core_tb.sv
